@@ hdl/udrb_pkg.sv @@
package udrb_pkg;

   localparam logic [2:0] OP_HOST_WRITE = 3'd0;
   localparam logic [2:0] OP_HOST_READ  = 3'd1;
   localparam logic [2:0] OP_RX_BYTE    = 3'd2;
   localparam logic [2:0] OP_TX_DONE    = 3'd3;
   localparam logic [2:0] OP_RX_FLUSH   = 3'd4;

   typedef struct packed {
      logic [2:0] opcode;
      logic [7:0] data_byte;
   } req_type;

   typedef struct packed {
      logic [7:0] read_byte;
      logic       read_ok;
      logic [7:0] send_byte;
      logic       send_valid;
      logic       rx_ready;
      logic       tx_idle;
   } rsp_type;

endpackage

@@ hdl/uart_dual_ring_buffer_top.sv @@
// Latency: the result of a transfer taken at one edge is on rsp_data, with rsp_strobe
// high, in the next cycle. Throughput: one transfer per cycle, busy stays low; the
// single synchronous read port of each ring and the result register set this figure.
// The receiver cannot stall; each result shows for exactly one cycle.
// Synchronous active-high reset clears all ring pointers, sets the transmitter idle
// and drops rsp_strobe; ring contents are left as they are.
module uart_dual_ring_buffer_top #(
   parameter int RX_DEPTH = 32,
   parameter int TX_DEPTH = 32
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  udrb_pkg::req_type req_data,
   output logic             rsp_strobe,
   output udrb_pkg::rsp_type rsp_data
);
   import udrb_pkg::*;

   localparam int RPW = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
   localparam int TPW = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
   localparam logic [RPW-1:0] RX_LAST = RPW'(RX_DEPTH - 1);
   localparam logic [TPW-1:0] TX_LAST = TPW'(TX_DEPTH - 1);

   logic [7:0] rx_mem [RX_DEPTH];
   logic [7:0] tx_mem [TX_DEPTH];

   logic [RPW-1:0] rx_wp_ff, rx_wp_in, rx_rp_ff, rx_rp_in, rx_wp_bump, rx_rp_bump;
   logic [TPW-1:0] tx_wp_ff, tx_wp_in, tx_rp_ff, tx_rp_in, tx_wp_bump, tx_rp_bump;
   logic           tx_empty_ff, tx_empty_in;
   logic           accept;
   logic           rx_we, tx_we;
   logic           read_ok_in, send_valid_in, bypass_in;

   logic           rsp_valid_ff;
   logic [7:0]     rx_q_ff, tx_q_ff, byte_ff;
   logic           read_ok_ff, send_valid_ff, bypass_ff, rx_ready_ff, tx_idle_ff;

   assign busy   = 1'b0;
   assign accept = start && !busy;

   assign rx_wp_bump = (rx_wp_ff == RX_LAST) ? '0 : rx_wp_ff + RPW'(1);
   assign rx_rp_bump = (rx_rp_ff == RX_LAST) ? '0 : rx_rp_ff + RPW'(1);
   assign tx_wp_bump = (tx_wp_ff == TX_LAST) ? '0 : tx_wp_ff + TPW'(1);
   assign tx_rp_bump = (tx_rp_ff == TX_LAST) ? '0 : tx_rp_ff + TPW'(1);

   always_comb begin
      rx_wp_in      = rx_wp_ff;
      rx_rp_in      = rx_rp_ff;
      tx_wp_in      = tx_wp_ff;
      tx_rp_in      = tx_rp_ff;
      tx_empty_in   = tx_empty_ff;
      rx_we         = 1'b0;
      tx_we         = 1'b0;
      read_ok_in    = 1'b0;
      send_valid_in = 1'b0;
      bypass_in     = 1'b0;
      unique case (req_data.opcode)
         OP_HOST_WRITE: begin
            tx_we    = 1'b1;
            tx_wp_in = tx_wp_bump;
            // idle ring is empty, so the new byte goes straight out
            if (tx_empty_ff) begin
               tx_empty_in   = 1'b0;
               send_valid_in = 1'b1;
               bypass_in     = 1'b1;
               tx_rp_in      = tx_rp_bump;
            end
         end
         OP_HOST_READ: begin
            if (rx_rp_ff != rx_wp_ff) begin
               read_ok_in = 1'b1;
               rx_rp_in   = rx_rp_bump;
            end
         end
         OP_RX_BYTE: begin
            rx_we    = 1'b1;
            rx_wp_in = rx_wp_bump;
         end
         OP_TX_DONE: begin
            if (tx_rp_ff != tx_wp_ff) begin
               send_valid_in = 1'b1;
               tx_rp_in      = tx_rp_bump;
            end else begin
               tx_empty_in = 1'b1;
            end
         end
         OP_RX_FLUSH: begin
            rx_wp_in = '0;
            rx_rp_in = '0;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept && rx_we) begin
         rx_mem[rx_wp_ff] <= req_data.data_byte;
      end
      rx_q_ff <= rx_mem[rx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (accept && tx_we) begin
         tx_mem[tx_wp_ff] <= req_data.data_byte;
      end
      tx_q_ff <= tx_mem[tx_rp_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_wp_ff     <= '0;
         rx_rp_ff     <= '0;
         tx_wp_ff     <= '0;
         tx_rp_ff     <= '0;
         tx_empty_ff  <= 1'b1;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= accept;
         if (accept) begin
            rx_wp_ff    <= rx_wp_in;
            rx_rp_ff    <= rx_rp_in;
            tx_wp_ff    <= tx_wp_in;
            tx_rp_ff    <= tx_rp_in;
            tx_empty_ff <= tx_empty_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         byte_ff       <= req_data.data_byte;
         read_ok_ff    <= read_ok_in;
         send_valid_ff <= send_valid_in;
         bypass_ff     <= bypass_in;
         rx_ready_ff   <= (rx_wp_in != rx_rp_in);
         tx_idle_ff    <= tx_empty_in;
      end
   end

   assign rsp_strobe          = rsp_valid_ff;
   assign rsp_data.read_byte  = read_ok_ff ? rx_q_ff : 8'd0;
   assign rsp_data.read_ok    = read_ok_ff;
   assign rsp_data.send_byte  = !send_valid_ff ? 8'd0 : (bypass_ff ? byte_ff : tx_q_ff);
   assign rsp_data.send_valid = send_valid_ff;
   assign rsp_data.rx_ready   = rx_ready_ff;
   assign rsp_data.tx_idle    = tx_idle_ff;

   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      !reset && accept |=> rsp_strobe)
      else $error("transfer taken without a result in the next cycle");

   a_no_spurious: assert property (@(posedge clock)
      !accept |=> !rsp_strobe)
      else $error("result strobe without a preceding transfer");

   a_send_not_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_data.send_valid |-> !rsp_data.tx_idle)
      else $error("byte sent while transmitter reported idle");

   a_idle_ring_empty: assert property (@(posedge clock) disable iff (reset)
      tx_empty_ff |-> tx_rp_ff == tx_wp_ff)
      else $error("transmitter idle with bytes still queued");

endmodule
